// ===== sv/hse_pkg.sv =====
// Shared constants, item types and controller/datapath interface types for the heap sorter.
`default_nettype none
package hse_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int CH_W       = IDX_W + 2;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_of_run;
    logic               overflow_flag;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_BSIFT,
    OP_EXT_INIT,
    OP_RD_POS,
    OP_RD_LEFT,
    OP_RD_RIGHT,
    OP_CMP,
    OP_WR_HELD,
    OP_RD_ROOT,
    OP_RD_K,
    OP_WR_K,
    OP_WR_ROOT,
    OP_EMIT_INIT,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic k_zero;
    logic n_small;
    logic left_out;
    logic move;
    logic next_in;
    logic emit_end;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/hse_ctrl.sv =====
// Sequencer for load, heap build, extraction and emit of one set.
`default_nettype none
module hse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          last_item,
  input  wire hse_pkg::sts_t sts,
  output hse_pkg::cmd_t      cmd,
  output logic               busy
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_BCHK = 13'b0000000000010,
    ST_SRDH = 13'b0000000000100,
    ST_SRDL = 13'b0000000001000,
    ST_SRDR = 13'b0000000010000,
    ST_SCMP = 13'b0000000100000,
    ST_SWH  = 13'b0000001000000,
    ST_ECHK = 13'b0000010000000,
    ST_XR0  = 13'b0000100000000,
    ST_XRK  = 13'b0001000000000,
    ST_XWK  = 13'b0010000000000,
    ST_XW0  = 13'b0100000000000,
    ST_EMIT = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   extr_r, extr_nxt;
  state_t ret_st;

  assign busy   = (state_r != ST_IDLE);
  assign ret_st = extr_r ? ST_ECHK : ST_BCHK;

  always_comb begin
    state_nxt = state_r;
    extr_nxt  = extr_r;
    cmd.op    = hse_pkg::OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.op = hse_pkg::OP_LOAD;
          if (last_item) begin
            state_nxt = ST_BCHK;
            extr_nxt  = 1'b0;
          end
        end
      end
      ST_BCHK: begin
        if (sts.n_small) begin
          cmd.op    = hse_pkg::OP_EMIT_INIT;
          state_nxt = ST_EMIT;
        end else if (sts.k_zero) begin
          cmd.op    = hse_pkg::OP_EXT_INIT;
          extr_nxt  = 1'b1;
          state_nxt = ST_ECHK;
        end else begin
          cmd.op    = hse_pkg::OP_BSIFT;
          state_nxt = ST_SRDH;
        end
      end
      ST_SRDH: begin
        cmd.op    = hse_pkg::OP_RD_POS;
        state_nxt = ST_SRDL;
      end
      ST_SRDL: begin
        cmd.op    = hse_pkg::OP_RD_LEFT;
        state_nxt = sts.left_out ? ret_st : ST_SRDR;
      end
      ST_SRDR: begin
        cmd.op    = hse_pkg::OP_RD_RIGHT;
        state_nxt = ST_SCMP;
      end
      ST_SCMP: begin
        cmd.op    = hse_pkg::OP_CMP;
        state_nxt = (sts.move && sts.next_in) ? ST_SRDR : ST_SWH;
      end
      ST_SWH: begin
        cmd.op    = hse_pkg::OP_WR_HELD;
        state_nxt = ret_st;
      end
      ST_ECHK: begin
        if (sts.k_zero) begin
          cmd.op    = hse_pkg::OP_EMIT_INIT;
          state_nxt = ST_EMIT;
        end else begin
          cmd.op    = hse_pkg::OP_RD_ROOT;
          state_nxt = ST_XRK;
        end
      end
      ST_XR0: begin
        cmd.op    = hse_pkg::OP_RD_ROOT;
        state_nxt = ST_XRK;
      end
      ST_XRK: begin
        cmd.op    = hse_pkg::OP_RD_K;
        state_nxt = ST_XWK;
      end
      ST_XWK: begin
        cmd.op    = hse_pkg::OP_WR_K;
        state_nxt = ST_XW0;
      end
      ST_XW0: begin
        cmd.op    = hse_pkg::OP_WR_ROOT;
        state_nxt = ST_SRDH;
      end
      ST_EMIT: begin
        cmd.op = hse_pkg::OP_EMIT;
        if (sts.emit_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      extr_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      extr_r  <= extr_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/hse_dpath.sv =====
// Heap store, sift and swap registers, and result register of the heap sorter.
`default_nettype none
module hse_dpath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hse_pkg::in_item_t in_data,
  input  wire hse_pkg::cmd_t     cmd,
  output hse_pkg::sts_t          sts,
  output logic                   out_valid,
  output hse_pkg::out_item_t     out_data
);

  localparam int DW   = hse_pkg::DATA_WIDTH;
  localparam int IW   = hse_pkg::IDX_W;
  localparam int CW   = hse_pkg::CNT_W;
  localparam int HW   = hse_pkg::CH_W;
  localparam int DEPTH = hse_pkg::DEPTH;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  logic [CW-1:0] fill_r, fill_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [HW-1:0] child_r, child_nxt;
  logic [DW-1:0] held_r, held_nxt;
  logic [DW-1:0] cval_r, cval_nxt;
  logic          rgt_r, rgt_nxt;
  logic          pend_r, pend_nxt;
  logic          plast_r, plast_nxt;
  logic          pover_r, pover_nxt;

  logic          we;
  logic [IW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [IW-1:0] raddr;

  logic          full;
  logic [CW-1:0] fill_inc;
  logic [HW-1:0] left_idx;
  logic [HW-1:0] len_ext;
  logic          rgt_gt;
  logic [DW-1:0] best_val;
  logic [HW-1:0] best_idx;
  logic [HW-1:0] best_child;
  logic          move;

  assign full       = (fill_r == CW'(DEPTH));
  assign fill_inc   = fill_r + CW'(1);
  assign len_ext    = HW'(len_r);
  assign left_idx   = HW'({pos_r, 1'b1});
  assign rgt_gt     = rgt_r && ($signed(rdata_r) > $signed(cval_r));
  assign best_val   = rgt_gt ? rdata_r : cval_r;
  assign best_idx   = rgt_gt ? (child_r + HW'(1)) : child_r;
  assign best_child = HW'({best_idx[IW-1:0], 1'b1});
  assign move       = $signed(best_val) > $signed(held_r);

  assign sts.k_zero   = (k_r == '0);
  assign sts.n_small  = (n_r < CW'(2));
  assign sts.left_out = (left_idx >= len_ext);
  assign sts.move     = move;
  assign sts.next_in  = (best_child < len_ext);
  assign sts.emit_end = ((k_r + CW'(1)) == n_r);

  always_comb begin
    fill_nxt  = fill_r;
    drop_nxt  = drop_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    child_nxt = child_r;
    held_nxt  = held_r;
    cval_nxt  = cval_r;
    rgt_nxt   = rgt_r;
    pend_nxt  = 1'b0;
    plast_nxt = plast_r;
    pover_nxt = pover_r;
    we        = 1'b0;
    waddr     = pos_r;
    wdata     = held_r;
    raddr     = '0;
    unique case (cmd.op)
      hse_pkg::OP_NONE: begin
      end
      hse_pkg::OP_LOAD: begin
        if (!full) begin
          we       = 1'b1;
          waddr    = fill_r[IW-1:0];
          wdata    = DW'(in_data.value);
          fill_nxt = fill_inc;
        end else begin
          drop_nxt = 1'b1;
        end
        n_nxt = full ? fill_r : fill_inc;
        k_nxt = n_nxt >> 1;
      end
      hse_pkg::OP_BSIFT: begin
        len_nxt = n_r;
        pos_nxt = IW'(k_r - CW'(1));
        k_nxt   = k_r - CW'(1);
      end
      hse_pkg::OP_EXT_INIT: begin
        k_nxt = n_r - CW'(1);
      end
      hse_pkg::OP_RD_POS: begin
        raddr = pos_r;
      end
      hse_pkg::OP_RD_LEFT: begin
        held_nxt  = rdata_r;
        child_nxt = left_idx;
        raddr     = left_idx[IW-1:0];
      end
      hse_pkg::OP_RD_RIGHT: begin
        cval_nxt = rdata_r;
        rgt_nxt  = ((child_r + HW'(1)) < len_ext);
        raddr    = IW'(child_r + HW'(1));
      end
      hse_pkg::OP_CMP: begin
        if (move) begin
          we        = 1'b1;
          waddr     = pos_r;
          wdata     = best_val;
          pos_nxt   = best_idx[IW-1:0];
          child_nxt = best_child;
          raddr     = best_child[IW-1:0];
        end
      end
      hse_pkg::OP_WR_HELD: begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = held_r;
      end
      hse_pkg::OP_RD_ROOT: begin
        raddr = '0;
      end
      hse_pkg::OP_RD_K: begin
        held_nxt = rdata_r;
        raddr    = k_r[IW-1:0];
      end
      hse_pkg::OP_WR_K: begin
        we       = 1'b1;
        waddr    = k_r[IW-1:0];
        wdata    = held_r;
        cval_nxt = rdata_r;
      end
      hse_pkg::OP_WR_ROOT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = cval_r;
        len_nxt = k_r;
        pos_nxt = '0;
        k_nxt   = k_r - CW'(1);
      end
      hse_pkg::OP_EMIT_INIT: begin
        k_nxt = '0;
      end
      hse_pkg::OP_EMIT: begin
        raddr     = k_r[IW-1:0];
        pend_nxt  = 1'b1;
        plast_nxt = sts.emit_end;
        pover_nxt = drop_r;
        k_nxt     = k_r + CW'(1);
        if (sts.emit_end) begin
          fill_nxt = '0;
          drop_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      drop_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      drop_r <= drop_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    len_r   <= len_nxt;
    pos_r   <= pos_nxt;
    child_r <= child_nxt;
    held_r  <= held_nxt;
    cval_r  <= cval_nxt;
    rgt_r   <= rgt_nxt;
    plast_r <= plast_nxt;
    pover_r <= pover_nxt;
  end

  assign out_valid              = pend_r;
  assign out_data.sorted_value  = $signed(32'(rdata_r));
  assign out_data.last_of_run   = plast_r;
  assign out_data.overflow_flag = pover_r;

endmodule
`default_nettype wire

// ===== sv/heap_sort_engine.sv =====
// Top level of the heap sorter: sequencer plus store datapath.
//
// Values are loaded one per cycle while busy is low; an item with last_item set
// closes the set and raises busy until the last sorted value has been read from
// the store. The set is heapsorted in place in a store with one read port and one
// write port (one read and one write per cycle): each sift level reads the right
// child, then compares and moves; each sift is set up by a check step and reads of
// the node and its left child; and each extraction swaps the root with the last
// heap item (read root, read last, write last, write root). The pace of the sort is
// set by that one store read port. Results then appear one per cycle in ascending
// order on out_data with out_valid high for one cycle each; the receiver cannot
// stall them. The last result shows in the first cycle after busy falls, while a
// new set may already be loading. Values beyond 64 are dropped and overflow_flag
// is set on every result of that set.
`default_nettype none
module heap_sort_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire hse_pkg::in_item_t in_data,
  output logic                   out_valid,
  output hse_pkg::out_item_t     out_data
);

  hse_pkg::cmd_t cmd;
  hse_pkg::sts_t sts;

  hse_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .last_item (in_data.last_item),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  hse_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
